// ===== src/scc_pkg.sv =====
// Package for the scratchpad CRC checker: frame constants, result type and
// the byte-wide reflected CRC-8 update. No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int unsigned CountWidth = 4;

    localparam logic [7:0]            CRC_POLY   = 8'h8C;
    localparam logic [CountWidth-1:0] FRAME_LOW  = 4'd0;
    localparam logic [CountWidth-1:0] FRAME_HIGH = 4'd1;
    localparam logic [CountWidth-1:0] FRAME_DATA = 4'd8;
    localparam logic [CountWidth-1:0] FRAME_DONE = 4'd9;

    typedef logic [CountWidth-1:0] count_t;

    typedef struct packed {
        logic               crc_ok;
        logic signed [15:0] temperature_raw;
        logic [7:0]         computed_crc;
    } result_t;

    // One byte through the reflected CRC-8, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ data_in[k]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/scc_frame.sv =====
// Frame tracker: byte counter, running CRC and held temperature bytes.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_frame (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       byte_value,
    input  logic             first_byte,
    output logic             emit,
    output scc_pkg::result_t result
);

    scc_pkg::count_t count_reg, count_next;
    logic [7:0]      crc_reg, crc_next;
    logic [7:0]      low_reg, low_next;
    logic [7:0]      high_reg, high_next;

    scc_pkg::count_t count_eff;
    logic [7:0]      crc_eff;

    always_comb begin
        // A start flag restarts the frame before the byte is taken.
        count_eff  = first_byte ? scc_pkg::FRAME_LOW : count_reg;
        crc_eff    = first_byte ? 8'h00 : crc_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        emit       = 1'b0;

        if (count_eff < scc_pkg::FRAME_DATA) begin
            if (count_eff == scc_pkg::FRAME_LOW) begin
                low_next = byte_value;
            end
            if (count_eff == scc_pkg::FRAME_HIGH) begin
                high_next = byte_value;
            end
            crc_next   = scc_pkg::crc8_byte(crc_eff, byte_value);
            count_next = count_eff + scc_pkg::count_t'(1);
        end else begin
            emit       = (count_eff == scc_pkg::FRAME_DATA) && accept;
            count_next = scc_pkg::FRAME_DONE;
        end

        result.crc_ok          = (crc_reg == byte_value);
        result.temperature_raw = {high_reg, low_reg};
        result.computed_crc    = crc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= scc_pkg::FRAME_LOW;
            crc_reg   <= 8'h00;
            low_reg   <= 8'h00;
            high_reg  <= 8'h00;
        end else if (accept) begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

endmodule

// ===== src/scc_out_reg.sv =====
// Result register: holds one finished result until the downstream takes it.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  scc_pkg::result_t load_data,
    input  logic             m_ready,
    output logic             m_valid,
    output logic             free,
    output scc_pkg::result_t m_data
);

    logic             valid_reg, valid_next;
    scc_pkg::result_t data_reg;

    // Space is available when empty or when the held result leaves now.
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== src/sensor_scratchpad_crc_check.sv =====
// Top level of the scratchpad CRC checker: frame tracker plus result register.
// Depends on scc_pkg, scc_frame and scc_out_reg.
//
//   channel  direction  request carries
//   s_       in         one scratchpad byte and its start-of-frame flag
//   m_       out        crc_ok, temperature_raw, computed_crc per frame
//
// One byte is taken per cycle while s_ready is high, which falls only while a
// result is held and m_ready is low. The CRC update is a byte-wide step
// between the running CRC register and the next. A frame's result appears the
// cycle after its ninth byte. Synchronous reset clears byte count and CRC.
`timescale 1ns / 1ps

module sensor_scratchpad_crc_check (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_value,
    input  logic               s_first_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_crc_ok,
    output logic signed [15:0] m_temperature_raw,
    output logic [7:0]         m_computed_crc
);

    logic             accept;
    logic             emit;
    logic             free;
    scc_pkg::result_t frame_result;
    scc_pkg::result_t out_data;

    assign s_ready = free;
    assign accept  = s_valid && free;

    scc_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_value (s_byte_value),
        .first_byte (s_first_byte),
        .emit       (emit),
        .result     (frame_result)
    );

    scc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (emit),
        .load_data (frame_result),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .free      (free),
        .m_data    (out_data)
    );

    assign m_crc_ok          = out_data.crc_ok;
    assign m_temperature_raw = out_data.temperature_raw;
    assign m_computed_crc    = out_data.computed_crc;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for sensor_scratchpad_crc_check: feeds scratchpad frames,
// predicts each frame's temperature, CRC and check flag, and compares results.
// Depends on scc_pkg and the sensor_scratchpad_crc_check RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RandomItems = 1800;
    localparam int unsigned CalmTail    = 250;
    localparam int unsigned DrainAt     = 1000;
    localparam int unsigned HoldAt      = 500;
    localparam int unsigned HoldCycles  = 300;

    typedef struct {
        logic [7:0] value;
        logic       first;
    } pad_byte_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_byte_value = 8'h00;
    logic               s_first_byte = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_crc_ok;
    logic signed [15:0] m_temperature_raw;
    logic [7:0]         m_computed_crc;

    pad_byte_t          byte_queue[$];
    scc_pkg::result_t   pending_readings[$];
    int unsigned        error_count = 0;
    int unsigned        bytes_taken = 0;
    int unsigned        items_sent = 0;
    int unsigned        send_gap = 0;
    int unsigned        stall_left = 0;
    int unsigned        hold_left = 0;
    logic               hold_done = 1'b0;

    // Predictor state, as left by reset.
    scc_pkg::count_t    frame_pos = scc_pkg::FRAME_LOW;
    logic [7:0]         crc_run = 8'h00;
    logic [7:0]         lsb_byte = 8'h00;
    logic [7:0]         msb_byte = 8'h00;

    sensor_scratchpad_crc_check u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_first_byte      (s_first_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_crc_ok          (m_crc_ok),
        .m_temperature_raw (m_temperature_raw),
        .m_computed_crc    (m_computed_crc)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Reflected CRC-8: shift right, fold in the polynomial when the bit out
    // differs from the data bit.
    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ scc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic start,
                             output logic produced, output scc_pkg::result_t r);
        produced = 1'b0;
        r = '0;
        if (start) begin
            frame_pos = scc_pkg::FRAME_LOW;
            crc_run   = 8'h00;
        end
        if (frame_pos < scc_pkg::FRAME_DATA) begin
            if (frame_pos == scc_pkg::FRAME_LOW) begin
                lsb_byte = b;
            end else if (frame_pos == scc_pkg::FRAME_HIGH) begin
                msb_byte = b;
            end
            crc_run   = crc_step(crc_run, b);
            frame_pos = frame_pos + 1'b1;
        end else if (frame_pos == scc_pkg::FRAME_DATA) begin
            r.crc_ok          = (crc_run == b);
            r.temperature_raw = {msb_byte, lsb_byte};
            r.computed_crc    = crc_run;
            produced          = 1'b1;
            frame_pos         = scc_pkg::FRAME_DONE;
        end
        // Past the ninth byte, unflagged bytes are dropped.
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic add_item(input logic [7:0] value, input logic first);
        pad_byte_t item;
        item.value = value;
        item.first = first;
        byte_queue.push_back(item);
    endtask

    // Nine bytes: data bytes 0..7, then the check byte, correct or corrupted.
    task automatic add_frame(input logic flag, input logic [7:0] data [8], input logic good);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            add_item(data[i], (i == 0) ? flag : 1'b0);
            crc = crc_step(crc, data[i]);
        end
        add_item(good ? crc : crc ^ 8'($urandom_range(1, 255)), 1'b0);
    endtask

    // Sender: holds a request until taken, inserts idle bursts, and once
    // waits for every outstanding result before going on.
    always @(posedge aclk) begin
        pad_byte_t nxt;
        logic      calm;
        calm = byte_queue.size() < CalmTail;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 8);
                s_valid  <= 1'b0;
            end else if (byte_queue.size() != 0 && (items_sent != DrainAt ||
                         (!s_valid && !m_valid && pending_readings.size() == 0))) begin
                nxt = byte_queue.pop_front();
                s_byte_value <= nxt.value;
                s_first_byte <= nxt.first;
                s_valid      <= 1'b1;
                items_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off that backs up the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else if (!hold_done && bytes_taken >= HoldAt) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (byte_queue.size() >= CalmTail && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Checker: compare any result first, since it belongs to an older request,
    // then predict from the request taken at this edge.
    always @(posedge aclk) begin
        scc_pkg::result_t want;
        scc_pkg::result_t fresh;
        logic             produced;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("result with no frame outstanding");
                end else begin
                    want = pending_readings.pop_front();
                    if (m_crc_ok !== want.crc_ok)
                        report_mismatch($sformatf("crc_ok %b, expected %b",
                                                  m_crc_ok, want.crc_ok));
                    if (m_temperature_raw !== want.temperature_raw)
                        report_mismatch($sformatf("temperature_raw %0d, expected %0d",
                                                  m_temperature_raw, want.temperature_raw));
                    if (m_computed_crc !== want.computed_crc)
                        report_mismatch($sformatf("computed_crc %h, expected %h",
                                                  m_computed_crc, want.computed_crc));
                end
            end
            if (s_valid && s_ready) begin
                bytes_taken++;
                take_byte(s_byte_value, s_first_byte, produced, fresh);
                if (produced) begin
                    pending_readings.push_back(fresh);
                end
            end
        end
    end

    initial begin
        logic [7:0] body [8];
        int unsigned pick;
        int unsigned extra;

        // Right after reset an unflagged byte still opens a frame: +2047.9375 deg.
        body = '{8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        add_frame(1'b0, body, 1'b1);
        add_item(8'h55, 1'b0);
        // A started frame cut short by a new start flag, then a bad check byte.
        add_item(8'hA5, 1'b1);
        add_item(8'h5A, 1'b0);
        add_item(8'hFF, 1'b0);
        body = '{8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_frame(1'b1, body, 1'b0);

        while (byte_queue.size() < RandomItems) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6 || pick == 9) begin
                for (int i = 0; i < 8; i++) begin
                    body[i] = 8'($urandom_range(0, 255));
                end
                add_frame(1'b1, body, $urandom_range(0, 2) != 0);
                if (pick == 9) begin
                    extra = $urandom_range(1, 3);
                    for (int i = 0; i < extra; i++) add_item(8'($urandom_range(0, 255)), 1'b0);
                end
            end else if (pick == 7) begin
                add_item(8'($urandom_range(0, 255)), 1'b1);
                extra = $urandom_range(0, 7);
                for (int i = 0; i < extra; i++) add_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                extra = $urandom_range(1, 4);
                for (int i = 0; i < extra; i++)
                    add_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (byte_queue.size() != 0 || s_valid || pending_readings.size() != 0);
        repeat (16) @(posedge aclk);

        if (error_count == 0) begin
            $display("[sensor_scratchpad_crc_check] OK");
        end else begin
            $display("[sensor_scratchpad_crc_check] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[sensor_scratchpad_crc_check] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/scc_pkg.sv
src/scc_frame.sv
src/scc_out_reg.sv
src/sensor_scratchpad_crc_check.sv
bench/tb_top.sv
